@@ rtl/star_wildcard_matcher_top_defines.svh @@
// ----------------------------------------------------------------------------
// Star wildcard matcher assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STAR_WILDCARD_MATCHER_TOP_DEFINES_SVH
`define STAR_WILDCARD_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("star matcher check failed");

// next-cycle implication, disabled in reset
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("star matcher check failed");

`endif

@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants shared by the star wildcard matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] DOT_BYTE   = 8'h2E;
  localparam logic       OP_PATTERN = 1'b0;
  localparam logic       OP_ENTRY   = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       is_last;
  } swm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } swm_out_t;

  // handed from each cell to its right neighbor
  typedef struct packed {
    logic pass;   // closed active bit sitting on a star
    logic step;   // literal byte matched, advance one position
    logic lead;   // start-closure bit for the neighbor
    logic wr;     // this cell is written this cycle
    logic valid;  // this cell holds a pattern byte
  } swm_link_t;

  // broadcast to every cell
  typedef struct packed {
    logic       clr;      // new pattern starts
    logic       ent;      // entry byte accepted
    logic       restart;  // entry byte begins a new entry
    logic [7:0] data;
  } swm_ctl_t;

endpackage

`default_nettype wire

@@ rtl/star_wildcard_matcher_top.sv @@
// Result: registered when the last entry byte is taken.
// Throughput: one request per cycle, pattern or entry, while in_stall is low;
// each byte's active-position update ripples combinationally across the cells.
// Reset: synchronous, active low; clears lengths, flags and active bits.
// Pattern bytes need no clearing, only loaded positions are ever read.
// ----------------------------------------------------------------------------
// star_wildcard_matcher_top
// Glob matcher with '*' as the only wildcard, built as a row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module star_wildcard_matcher_top
  import swm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  swm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output swm_out_t out_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [LEN_W-1:0]     len_r, len_nxt, wpos;
  logic                 ovf_r, ovf_nxt;
  logic                 prst_r, prst_nxt;
  logic                 erst_r, erst_nxt;
  logic                 hid_r, hid_nxt;
  logic                 fdot_r, fdot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  swm_out_t             out_data_r;

  logic                 in_acc, pat_acc, ent_acc, room;
  logic                 hid_new, hid_eff, hit_end, any_hit;
  swm_ctl_t             ctl;
  logic [PATTERN_MAX-1:0] wr;
  logic [PATTERN_MAX-1:0] hit;
  swm_link_t            link [PATTERN_MAX+1];

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign pat_acc   = in_acc & (in_data.opcode == OP_PATTERN);
  assign ent_acc   = in_acc & (in_data.opcode == OP_ENTRY);
  assign wpos      = prst_r ? '0 : len_r;
  assign room      = wpos < LEN_W'(PATTERN_MAX);

  assign ctl.clr     = pat_acc & prst_r;
  assign ctl.ent     = ent_acc;
  assign ctl.restart = erst_r;
  assign ctl.data    = in_data.data_byte;

  assign link[0] = '{pass: 1'b0, step: 1'b0, lead: 1'b1, wr: 1'b0, valid: 1'b1};

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    assign wr[i] = pat_acc & room & (wpos == LEN_W'(i));
    swm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .wr    (wr[i]),
      .left  (link[i]),
      .right (link[i+1]),
      .hit   (hit[i])
    );
  end

  assign hit_end = (link[PATTERN_MAX].pass | link[PATTERN_MAX].step) &
                   link[PATTERN_MAX].valid;
  assign any_hit = (|hit) | hit_end;

  always_comb begin
    hid_new = (in_data.data_byte == DOT_BYTE) && !((len_r != '0) && fdot_r);
    hid_eff = erst_r ? hid_new : hid_r;

    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    prst_nxt = prst_r;
    erst_nxt = erst_r;
    hid_nxt  = hid_r;
    fdot_nxt = wr[0] ? (in_data.data_byte == DOT_BYTE) : fdot_r;

    if (pat_acc) begin
      len_nxt  = wpos + {{(LEN_W-1){1'b0}}, room};
      ovf_nxt  = (prst_r ? 1'b0 : ovf_r) | ~room;
      prst_nxt = in_data.is_last;
      erst_nxt = 1'b1;
    end else if (ent_acc) begin
      erst_nxt = in_data.is_last;
      hid_nxt  = hid_eff;
    end

    out_valid_nxt = out_valid_r & out_stall;
    if (ent_acc && in_data.is_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      prst_r      <= 1'b1;
      erst_r      <= 1'b1;
      hid_r       <= 1'b0;
      fdot_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      prst_r      <= prst_nxt;
      erst_r      <= erst_nxt;
      hid_r       <= hid_nxt;
      fdot_r      <= fdot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_acc && in_data.is_last) begin
      out_data_r.matched          <= any_hit & ~hid_eff & ~ovf_r;
      out_data_r.pattern_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// One pattern position: stored byte, valid bit, start-closure bit and the
// active bit for this position, updated once per entry byte.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
  import swm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  swm_ctl_t  ctl,
  input  logic      wr,
  input  swm_link_t left,
  output swm_link_t right,
  output logic      hit
);

  logic [7:0] byte_r;
  logic       valid_r, valid_nxt;
  logic       lead_r, lead_nxt;
  logic       act_r, act_nxt;
  logic       star, act_eff;

  always_comb begin
    star      = valid_r && (byte_r == STAR_BYTE);
    act_eff   = ctl.restart ? lead_r : act_r;
    act_nxt   = (act_eff & star) | left.step | left.pass;
    valid_nxt = wr ? 1'b1 : (ctl.clr ? 1'b0 : valid_r);
    lead_nxt  = left.wr ? left.lead : lead_r;

    right.pass  = act_nxt & star;
    right.step  = act_eff & valid_r & ~star & (byte_r == ctl.data);
    right.lead  = lead_r & (ctl.data == STAR_BYTE);
    right.wr    = wr;
    right.valid = valid_r;

    hit = act_nxt & left.valid & ~valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lead_r  <= 1'b1;
      act_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lead_r  <= lead_nxt;
      if (ctl.ent) begin
        act_r <= act_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      byte_r <= ctl.data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/swm_checker.sv @@
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the star wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "star_wildcard_matcher_top_defines.svh"

module swm_checker
  import swm_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire swm_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire swm_out_t out_data
);

  `SWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SWM_ASSERT_NOW(a_no_match_on_ovf, out_valid, !(out_data.matched && out_data.pattern_overflow))
  `SWM_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `SWM_ASSERT_NEXT(a_last_gives_result, in_valid && !in_stall && (in_data.opcode == OP_ENTRY) && in_data.is_last, out_valid)

endmodule

bind star_wildcard_matcher_top swm_checker u_swm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the star wildcard matcher. A short directed table
// covers the empty pattern, hidden names, star runs and extreme bytes.
// Random pattern loads and entry names follow, with random gaps on the input
// and stalls on the output. Each result is checked against a matcher model or a fixed table value.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int PAT_MAX        = 32;
  localparam int N_ITEMS        = 1150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] SYM_A  = 8'h61;
  localparam logic [7:0] SYM_B  = 8'h62;
  localparam logic [7:0] SYM_C  = 8'h63;

  typedef struct {
    swm_in_t  req;
    bit       fixed;
    swm_out_t res;
  } dir_row_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  swm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  swm_out_t out_data;

  star_wildcard_matcher_top #(
    .PATTERN_MAX(PAT_MAX)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // matcher model state
  logic [7:0]       pat_mem [PAT_MAX];
  int               pat_len  = 0;
  logic [PAT_MAX:0] live     = {{PAT_MAX{1'b0}}, 1'b1};
  bit               ovf      = 1'b0;
  bit               pat_new  = 1'b1;
  bit               ent_new  = 1'b1;
  bit               hide     = 1'b0;

  swm_out_t   match_q [$];
  logic [7:0] gen_pat [$];
  bit         gen_closed = 1'b1;
  dir_row_t   dir_tab [$];

  int  err_count = 0;
  int  n_in      = 0;
  int  n_out     = 0;
  int  n_match   = 0;
  int  n_ovf     = 0;
  int  quiet     = 0;
  bit  in_burst  = 1'b0;
  bit  out_burst = 1'b0;

  function automatic logic [PAT_MAX:0] star_close(input logic [PAT_MAX:0] a);
    logic [PAT_MAX:0] c;
    c = a;
    for (int i = 0; i < PAT_MAX; i++)
      if (i < pat_len && c[i] && pat_mem[i] == STAR_BYTE) c[i+1] = 1'b1;
    return c;
  endfunction

  task automatic match_step(input swm_in_t r, output bit has, output swm_out_t res);
    logic [PAT_MAX:0] nxt;
    has = 1'b0;
    res = '0;
    if (r.opcode == OP_PATTERN) begin
      if (pat_new) begin
        pat_len = 0;
        ovf     = 1'b0;
      end
      if (pat_len < PAT_MAX) begin
        pat_mem[pat_len] = r.data_byte;
        pat_len++;
      end else begin
        ovf = 1'b1;
      end
      pat_new = r.is_last;
      ent_new = 1'b1;
    end else begin
      if (ent_new) begin
        live = star_close({{PAT_MAX{1'b0}}, 1'b1});
        hide = (r.data_byte == DOT_BYTE) && !(pat_len > 0 && pat_mem[0] == DOT_BYTE);
      end
      nxt = '0;
      for (int i = 0; i < PAT_MAX; i++)
        if (i < pat_len && live[i]) begin
          if (pat_mem[i] == STAR_BYTE) nxt[i] = 1'b1;
          else if (pat_mem[i] == r.data_byte) nxt[i+1] = 1'b1;
        end
      live    = star_close(nxt);
      ent_new = r.is_last;
      if (r.is_last) begin
        has                  = 1'b1;
        res.matched          = live[pat_len] && !hide && !ovf;
        res.pattern_overflow = ovf;
      end
    end
  endtask

  task automatic send(input swm_in_t r, input bit fixed, input swm_out_t fixed_res);
    int       gap;
    bit       has;
    swm_out_t res;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    match_step(r, has, res);
    if (has) match_q.push_back(fixed ? fixed_res : res);
    if (r.opcode == OP_PATTERN) begin
      if (gen_closed) gen_pat.delete();
      gen_pat.push_back(r.data_byte);
      gen_closed = r.is_last;
    end
    n_in++;
    if (n_in % 64 == 0) in_burst = ($urandom_range(0, 3) == 0);
  endtask

  function automatic void add_row(input logic op, input logic [7:0] b, input logic last,
                                  input bit fixed = 1'b0, input logic m = 1'b0,
                                  input logic o = 1'b0);
    dir_row_t row;
    row.req.opcode               = op;
    row.req.data_byte            = b;
    row.req.is_last              = last;
    row.fixed                    = fixed;
    row.res.matched              = m;
    row.res.pattern_overflow     = o;
    dir_tab.push_back(row);
  endfunction

  function automatic logic [7:0] pick_sym();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: return SYM_A;
      3, 4:    return SYM_B;
      5, 6:    return STAR_BYTE;
      7:       return DOT_BYTE;
      8:       return SYM_C;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pattern(input int len, input bit close);
    swm_in_t r;
    for (int i = 0; i < len; i++) begin
      r.opcode    = OP_PATTERN;
      r.data_byte = pick_sym();
      r.is_last   = close && (i == len - 1);
      send(r, 1'b0, '0);
    end
  endtask

  // derived names follow the current pattern, with stars expanded and rare slips
  task automatic send_name(input bit derived, input bit finish);
    logic [7:0] nm [$];
    swm_in_t    r;
    int         n;
    if (derived) begin
      foreach (gen_pat[i]) begin
        if (gen_pat[i] == STAR_BYTE) begin
          n = $urandom_range(0, 3);
          repeat (n) nm.push_back(pick_sym());
        end else if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1)) nm.push_back(pick_sym());
        end else begin
          nm.push_back(gen_pat[i]);
        end
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) nm.push_back(pick_sym());
    end
    if (nm.size() == 0) nm.push_back(pick_sym());
    n = finish ? nm.size() : $urandom_range(1, nm.size());
    for (int i = 0; i < n; i++) begin
      r.opcode    = OP_ENTRY;
      r.data_byte = nm[i];
      r.is_last   = finish && (i == n - 1);
      send(r, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    swm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (out_data.matched) n_match++;
      if (out_data.pattern_overflow) n_ovf++;
      if (match_q.size() == 0) begin
        $error("unexpected result: matched %0b, pattern_overflow %0b",
               out_data.matched, out_data.pattern_overflow);
        err_count++;
      end else begin
        want = match_q.pop_front();
        if (out_data.matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_data.matched);
          err_count++;
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          $error("pattern_overflow: expected %0b, got %0b",
                 want.pattern_overflow, out_data.pattern_overflow);
          err_count++;
        end
      end
    end
  end

  initial begin
    int gap;
    int got;
    got = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (got % 32 == 0) out_burst = ($urandom_range(0, 3) == 0);
      gap = out_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      got++;
    end
  end

  always @(posedge clk)
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;

  initial begin
    wait (quiet >= WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int      k;
    swm_in_t r;
    foreach (pat_mem[i]) pat_mem[i] = '0;

    // empty pattern after reset, then a lone star
    add_row(OP_ENTRY,   SYM_A,     1'b1, 1'b1, 1'b0, 1'b0);
    add_row(OP_PATTERN, STAR_BYTE, 1'b1);
    add_row(OP_ENTRY,   DOT_BYTE,  1'b1, 1'b1, 1'b0, 1'b0);
    add_row(OP_ENTRY,   8'h00,     1'b0);
    add_row(OP_ENTRY,   8'hFF,     1'b1, 1'b1, 1'b1, 1'b0);
    // entry while the pattern is still loading
    add_row(OP_PATTERN, DOT_BYTE,  1'b0);
    add_row(OP_ENTRY,   DOT_BYTE,  1'b1);
    add_row(OP_PATTERN, STAR_BYTE, 1'b1);
    add_row(OP_ENTRY,   DOT_BYTE,  1'b0);
    add_row(OP_ENTRY,   8'h7A,     1'b1);
    // pattern request aborts an open entry
    add_row(OP_ENTRY,   SYM_A,     1'b0);
    add_row(OP_PATTERN, SYM_A,     1'b1);
    add_row(OP_ENTRY,   SYM_A,     1'b1);
    // star run followed by a literal; name ending inside the stars
    add_row(OP_PATTERN, SYM_A,     1'b0);
    add_row(OP_PATTERN, STAR_BYTE, 1'b0);
    add_row(OP_PATTERN, STAR_BYTE, 1'b0);
    add_row(OP_PATTERN, SYM_C,     1'b1);
    add_row(OP_ENTRY,   SYM_A,     1'b1);
    add_row(OP_ENTRY,   SYM_A,     1'b0);
    add_row(OP_ENTRY,   SYM_B,     1'b0);
    add_row(OP_ENTRY,   SYM_C,     1'b1);
    add_row(OP_PATTERN, 8'hFF,     1'b1);
    add_row(OP_ENTRY,   8'hFF,     1'b1, 1'b1, 1'b1, 1'b0);
    add_row(OP_ENTRY,   8'h00,     1'b1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].res);

    while (n_in < N_ITEMS) begin
      k = $urandom_range(0, 19);
      if (k < 12) begin
        send_name($urandom_range(0, 3) != 0, 1'b1);
      end else if (k < 15) begin
        if ($urandom_range(0, 9) == 0) send_pattern($urandom_range(30, 36), 1'b1);
        else send_pattern($urandom_range(1, 8), 1'b1);
      end else if (k < 17) begin
        send_name($urandom_range(0, 1) != 0, 1'b0);
        send_pattern($urandom_range(1, 6), 1'b1);
      end else if (k < 19) begin
        send_pattern($urandom_range(1, 4), 1'b0);
        send_name($urandom_range(0, 1) != 0, 1'b1);
        send_pattern($urandom_range(1, 4), 1'b1);
      end else begin
        r = 10'($urandom);
        send(r, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (match_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d pattern and name requests; checked %0d results.", n_in, n_out);
    $display("Of those, %0d matched and %0d reported pattern overflow.", n_match, n_ovf);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ star_wildcard_matcher_top.f @@
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/star_wildcard_matcher_top.sv
rtl/swm_checker.sv
tb/testbench.sv
